[hw/rtl/software_timer_table_core_macros.svh]
// assertion macros used by the timer table datapath
// expects clk and arst_n in scope at the point of use
`ifndef SOFTWARE_TIMER_TABLE_CORE_MACROS_SVH
`define SOFTWARE_TIMER_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define STT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define STT_NEVER(label, expr, msg) \
	`STT_ASSERT(label, !(expr), msg)
`else
`define STT_ASSERT(label, prop, msg)
`define STT_NEVER(label, expr, msg)
`endif
`endif

[hw/rtl/stt_pkg.sv]
// shared types and constants for the software timer table
// no dependencies
package stt_pkg;

	localparam int TIMER_COUNT = 16;
	localparam int SLOT_W      = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

	localparam int IDX_W  = 4;
	localparam int KIND_W = 2;
	localparam int TIME_W = 32;
	localparam int TAG_W  = 8;
	localparam int ARG_W  = 32;
	localparam int PRIO_W = 8;

	// slot record: kind, period, handler tag, handler word
	localparam int REC_W = KIND_W + TIME_W + TAG_W + ARG_W;

	localparam int IN_TDATA_W  = 112;
	localparam int OUT_TDATA_W = 56;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_RESET = 2'd2,
		OP_TICK  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		RES_CMD       = 2'd0,
		RES_FIRE      = 2'd1,
		RES_TICK_DONE = 2'd2
	} result_kind_t;

	localparam logic [KIND_W-1:0] TT_ONESHOT          = 2'd0;
	localparam logic [KIND_W-1:0] TT_PERIODIC_DEFERRED = 2'd1;

	typedef struct packed {
		logic in_ready;
		logic in_take;
		logic scan_clear;
		logic scan_next;
		logic do_cmd;
		logic do_fire;
		logic do_done;
	} ctrl_cmd_t;

	typedef struct packed {
		logic slot_active;
		logic fire_hit;
		logic scan_last;
		logic out_free;
	} dp_status_t;

endpackage

[hw/rtl/software_timer_table_core.sv]
// top level of the software timer table: stream ports, controller, datapath
// depends on stt_pkg, stt_ctrl and stt_datapath
//
// Commands enter on the s_axis channel (tuser = opcode) and results leave on
// m_axis (tuser = result kind, tlast = final result of the command).
// start, stop and reset each give one result, loaded into the output register
// once it is free after the command is accepted. A tick walks all slots in
// index order: an inactive slot is skipped without a read, an armed slot is
// read from the slot rams (registered read port) and then compared, and a
// tick done result follows the last slot. The scan steps one slot at a time
// over the single read port of each slot ram.
// One command is worked at a time; s_axis_tready is high only while idle,
// and the next command may be taken while the last result still waits.
// If the receiver stalls, the result is held in the output register and the
// scan waits on it. Reset clears all active marks, the deferred priority
// register and the output valid flag. The cfg channel (always ready) writes
// the deferred priority and is meant to be used while the block is idle.
module software_timer_table_core
	import stt_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// timer_index, timer_type, interval_ms, now_ms, handler_id, handler_arg
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// opcode
	input  logic [1:0]             s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// fired_index, immediate, status, fired_handler, fired_arg, task_priority
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// result_kind
	output logic [1:0]             m_axis_tuser,
	output logic                   m_axis_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [PRIO_W-1:0]      cfg_data
);

	ctrl_cmd_t    cmd;
	dp_status_t   status;
	result_kind_t res_kind;
	logic [IDX_W-1:0]  res_idx;
	logic              res_imm;
	logic              res_status;
	logic [TAG_W-1:0]  res_handler;
	logic [ARG_W-1:0]  res_arg;
	logic [PRIO_W-1:0] res_prio;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = cmd.in_ready;

	stt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (opcode_t'(s_axis_tuser)),
		.status   (status),
		.cmd      (cmd)
	);

	stt_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.in_opcode         (s_axis_tuser),
		.in_timer_index    (s_axis_tdata[3:0]),
		.in_timer_type     (s_axis_tdata[5:4]),
		.in_interval_ms    (s_axis_tdata[37:6]),
		.in_now_ms         (s_axis_tdata[69:38]),
		.in_handler_id     (s_axis_tdata[77:70]),
		.in_handler_arg    (s_axis_tdata[109:78]),
		.cfg_valid         (cfg_valid),
		.cfg_data          (cfg_data),
		.m_ready           (m_axis_tready),
		.out_valid         (m_axis_tvalid),
		.out_result_kind   (res_kind),
		.out_fired_index   (res_idx),
		.out_immediate     (res_imm),
		.out_status        (res_status),
		.out_fired_handler (res_handler),
		.out_fired_arg     (res_arg),
		.out_task_priority (res_prio),
		.out_last          (m_axis_tlast)
	);

	assign m_axis_tuser = res_kind;
	assign m_axis_tdata = {2'b00, res_prio, res_arg, res_handler, res_status, res_imm, res_idx};

endmodule

[hw/rtl/stt_ram.sv]
// generic single write port ram with one registered read port
// no dependencies
module stt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/stt_ctrl.sv]
// sequencer for the timer table: commands, slot scan on tick, tick done
// depends on stt_pkg
module stt_ctrl
	import stt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  opcode_t    in_op,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMD,
		ST_READ,
		ST_EVAL,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   advance;

	assign advance = !status.fire_hit || status.out_free;

	always_comb begin
		cmd            = '0;
		cmd.in_ready   = (state_q == ST_IDLE);
		cmd.in_take    = cmd.in_ready && in_valid;
		cmd.scan_clear = cmd.in_take;
		unique case (state_q)
			ST_IDLE: ;
			ST_CMD: cmd.do_cmd = status.out_free;
			// inactive slots are skipped without a read
			ST_READ: cmd.scan_next = !status.slot_active && !status.scan_last;
			ST_EVAL: begin
				cmd.do_fire   = status.fire_hit && status.out_free;
				cmd.scan_next = advance && !status.scan_last;
			end
			ST_DONE: cmd.do_done = status.out_free;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.in_take) begin
						state_q <= (in_op == OP_TICK) ? ST_READ : ST_CMD;
					end
				end
				ST_CMD: begin
					if (status.out_free) state_q <= ST_IDLE;
				end
				ST_READ: begin
					if (status.slot_active) state_q <= ST_EVAL;
					else if (status.scan_last) state_q <= ST_DONE;
				end
				ST_EVAL: begin
					if (advance) state_q <= status.scan_last ? ST_DONE : ST_READ;
				end
				ST_DONE: begin
					if (status.out_free) state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/stt_datapath.sv]
// timer table datapath: input and config registers, active bits, slot rams,
// expiry compare, scan counter and output register
// depends on stt_pkg, stt_ram and the assertion macro header
`include "software_timer_table_core_macros.svh"

module stt_datapath
	import stt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         cmd,
	output dp_status_t        status,
	input  logic [1:0]        in_opcode,
	input  logic [IDX_W-1:0]  in_timer_index,
	input  logic [KIND_W-1:0] in_timer_type,
	input  logic [TIME_W-1:0] in_interval_ms,
	input  logic [TIME_W-1:0] in_now_ms,
	input  logic [TAG_W-1:0]  in_handler_id,
	input  logic [ARG_W-1:0]  in_handler_arg,
	input  logic              cfg_valid,
	input  logic [PRIO_W-1:0] cfg_data,
	input  logic              m_ready,
	output logic              out_valid,
	output result_kind_t      out_result_kind,
	output logic [IDX_W-1:0]  out_fired_index,
	output logic              out_immediate,
	output logic              out_status,
	output logic [TAG_W-1:0]  out_fired_handler,
	output logic [ARG_W-1:0]  out_fired_arg,
	output logic [PRIO_W-1:0] out_task_priority,
	output logic              out_last
);

	// latched transaction
	opcode_t           op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [KIND_W-1:0] typ_q;
	logic [TIME_W-1:0] intv_q;
	logic [TIME_W-1:0] now_q;
	logic [TAG_W-1:0]  hid_q;
	logic [ARG_W-1:0]  harg_q;

	logic [PRIO_W-1:0]      prio_q;
	logic [TIMER_COUNT-1:0] active_q;
	logic [SLOT_W-1:0]      scan_q;

	logic              out_valid_q;
	result_kind_t      out_kind_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic              out_imm_q;
	logic              out_status_q;
	logic [TAG_W-1:0]  out_handler_q;
	logic [ARG_W-1:0]  out_arg_q;
	logic [PRIO_W-1:0] out_prio_q;
	logic              out_last_q;

	logic [SLOT_W-1:0] cmd_slot;
	logic              idx_ok;
	logic              cmd_found;

	logic              rec_we;
	logic [REC_W-1:0]  rec_wdata;
	logic [REC_W-1:0]  rec_rd;
	logic              st_we;
	logic [SLOT_W-1:0] st_waddr;
	logic [TIME_W-1:0] st_wdata;
	logic [TIME_W-1:0] start_rd;

	logic [KIND_W-1:0] kind_rd;
	logic [TIME_W-1:0] period_rd;
	logic [TAG_W-1:0]  tag_rd;
	logic [ARG_W-1:0]  word_rd;
	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] next_start;
	logic              fire_deferred;
	logic              oneshot_fire;
	logic              load;

	assign idx_ok    = (32'(idx_q) < 32'(TIMER_COUNT));
	assign cmd_slot  = SLOT_W'(idx_q);
	assign cmd_found = idx_ok && active_q[cmd_slot];

	assign {kind_rd, period_rd, tag_rd, word_rd} = rec_rd;
	assign rec_wdata = {typ_q, intv_q, hid_q, harg_q};

	// wrapping elapsed time against the interval
	assign elapsed       = now_q - start_rd;
	assign next_start    = start_rd + period_rd;
	assign fire_deferred = (kind_rd == TT_ONESHOT) || (kind_rd == TT_PERIODIC_DEFERRED);
	assign oneshot_fire  = cmd.do_fire && (kind_rd == TT_ONESHOT);

	assign status.slot_active = active_q[scan_q];
	assign status.fire_hit    = (elapsed >= period_rd);
	assign status.scan_last   = (scan_q == SLOT_W'(TIMER_COUNT - 1));
	assign status.out_free    = !out_valid_q || m_ready;

	assign load = cmd.do_cmd || cmd.do_fire || cmd.do_done;

	always_comb begin
		rec_we   = 1'b0;
		st_we    = 1'b0;
		st_waddr = scan_q;
		st_wdata = next_start;
		if (cmd.do_cmd) begin
			case (op_q)
				OP_START: begin
					rec_we   = idx_ok;
					st_we    = idx_ok;
					st_waddr = cmd_slot;
					st_wdata = now_q;
				end
				OP_RESET: begin
					st_we    = cmd_found;
					st_waddr = cmd_slot;
					st_wdata = now_q;
				end
				default: ;
			endcase
		end else if (cmd.do_fire) begin
			st_we = (kind_rd != TT_ONESHOT);
		end
	end

	stt_ram #(
		.WIDTH (REC_W),
		.DEPTH (TIMER_COUNT)
	) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (cmd_slot),
		.wdata (rec_wdata),
		.raddr (scan_q),
		.rdata (rec_rd)
	);

	stt_ram #(
		.WIDTH (TIME_W),
		.DEPTH (TIMER_COUNT)
	) u_start_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (scan_q),
		.rdata (start_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.in_take) begin
			op_q   <= opcode_t'(in_opcode);
			idx_q  <= in_timer_index;
			typ_q  <= in_timer_type;
			intv_q <= in_interval_ms;
			now_q  <= in_now_ms;
			hid_q  <= in_handler_id;
			harg_q <= in_handler_arg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_q   <= '0;
			active_q <= '0;
			scan_q   <= '0;
		end else begin
			if (cfg_valid) prio_q <= cfg_data;
			if (cmd.scan_clear) scan_q <= '0;
			else if (cmd.scan_next) scan_q <= scan_q + 1'b1;
			if (cmd.do_cmd) begin
				if (op_q == OP_START && idx_ok) active_q[cmd_slot] <= 1'b1;
				else if (op_q == OP_STOP && cmd_found) active_q[cmd_slot] <= 1'b0;
			end else if (cmd.do_fire && kind_rd == TT_ONESHOT) begin
				active_q[scan_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_cmd) begin
			out_kind_q    <= RES_CMD;
			out_idx_q     <= idx_q;
			out_imm_q     <= 1'b0;
			out_status_q  <= (op_q == OP_START) ? !idx_ok : !cmd_found;
			out_handler_q <= '0;
			out_arg_q     <= '0;
			out_prio_q    <= '0;
			out_last_q    <= 1'b1;
		end else if (cmd.do_fire) begin
			out_kind_q    <= RES_FIRE;
			out_idx_q     <= IDX_W'(scan_q);
			out_imm_q     <= !fire_deferred;
			out_status_q  <= 1'b0;
			out_handler_q <= tag_rd;
			out_arg_q     <= word_rd;
			out_prio_q    <= fire_deferred ? prio_q : '0;
			out_last_q    <= 1'b0;
		end else if (cmd.do_done) begin
			out_kind_q    <= RES_TICK_DONE;
			out_idx_q     <= '0;
			out_imm_q     <= 1'b0;
			out_status_q  <= 1'b0;
			out_handler_q <= '0;
			out_arg_q     <= '0;
			out_prio_q    <= '0;
			out_last_q    <= 1'b1;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_result_kind   = out_kind_q;
	assign out_fired_index   = out_idx_q;
	assign out_immediate     = out_imm_q;
	assign out_status        = out_status_q;
	assign out_fired_handler = out_handler_q;
	assign out_fired_arg     = out_arg_q;
	assign out_task_priority = out_prio_q;
	assign out_last          = out_last_q;

	`STT_NEVER(a_no_overwrite, load && out_valid_q && !m_ready, "result register overwritten")
	`STT_ASSERT(a_single_load, $onehot0({cmd.do_cmd, cmd.do_fire, cmd.do_done}), "two loads")
	`STT_ASSERT(a_oneshot_clears, oneshot_fire |=> !active_q[$past(scan_q)], "one-shot armed")
	`STT_NEVER(a_fire_not_last, out_valid_q && out_kind_q == RES_FIRE && out_last_q, "fire last")

endmodule
